// ===== rtl/ihx_pkg.sv =====
// Shared types and constants for the Intel HEX record parser.
// Holds character codes, record types, result kinds, error codes and decoder state.
// No dependencies.
package ihx_pkg;

    // Parser phases.
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_REC  = 2'd1;
    localparam logic [1:0] PH_HALT = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Record types.
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_HEX       = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
    localparam logic [2:0] ERR_START_REC = 3'd5;
    localparam logic [2:0] ERR_TYPE      = 3'd6;

    // Bytes of header and checksum around the data.
    localparam logic [8:0] HDR_BYTES = 9'd4;
    localparam logic [8:0] FRAME_BYTES = 9'd5;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  high_nibble;
        logic        nibble_pending;
        logic [8:0]  byte_index;
        logic [7:0]  record_length;
        logic [15:0] record_offset;
        logic [7:0]  record_type;
        logic [7:0]  running_sum;
        logic [15:0] segment_base;
        logic [15:0] linear_base;
        logic [15:0] pending_base;
        logic [31:0] base_address;   // segment_base*16 + linear_base*65536
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
    } t_result;

    // Hex digit decode: {valid, value}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/intel_hex_record_parser.sv =====
// Intel HEX record parser, top level: input register, decode step, result register.
// Streams ASCII characters in and data bytes, record verdicts and errors out.
// Depends on ihx_pkg and ihx_step.

// One character is taken per transfer on the slave side, one character per clock
// when both sides keep up. A character's result, if it has one, reaches the master
// side by way of the input register and then the result register: the character sits
// in the input register while the decode step fills the result register, which drives
// the master side. The sustained rate of one character per cycle, when both sides keep
// up, is set by the single decode step, which updates the record state once per
// character.
// Each character yields at most one result: a data byte with its absolute address
// (segment*16 + linear*65536 + offset + index, wrapping at 32 bits), a record accepted,
// an end-of-file record, or an error with its code. A newline, or a character marked
// with tlast, closes the record. Extended segment and linear address records update
// their base only once the record passes its checks. After an error or an end-of-file
// record every further character is taken and dropped until reset, so downstream must
// discard the whole image if any error is reported. The result register frees up in
// the same cycle its transfer completes, so a stalled master side holds one result
// while one more character waits in the input register.
module intel_hex_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // final_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] byte_address, [39:32] data_byte,
                                        // [42:40] error_code, [47:43] zero
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_final;

    // Decoder state.
    ihx_pkg::t_state r_state;
    ihx_pkg::t_state n_state;

    // Result register.
    logic             r_out_valid;
    ihx_pkg::t_result r_out;

    logic             res_valid;
    ihx_pkg::t_result res;
    logic             advance;

    // Move the held character through the decoder when the result register can take
    // whatever it produces.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    ihx_step u_step (
        .i_state     (r_state),
        .i_ch        (r_ch),
        .i_final     (r_final),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Capture a new character on every transfer; drop the valid flag once consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_ch    <= s_axis_tdata;
            r_final <= s_axis_tlast;
        end
    end

    // Advance the record state one character at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Load a fresh result on advance; otherwise clear it once transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out.error_code, r_out.data_byte, r_out.byte_address};
    assign m_axis_tuser  = r_out.kind;

`ifndef SYNTHESIS
    // Halt is permanent until reset.
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == ihx_pkg::PH_HALT) |=> (r_state.phase == ihx_pkg::PH_HALT))
        else $error("parser left halt without reset");

    // A character consumed while halted leaves no result behind.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_state.phase == ihx_pkg::PH_HALT) |=> !m_axis_tvalid)
        else $error("result produced while halted");

    // Error results always carry a code, other results never do.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ihx_pkg::KIND_ERROR) ==
                           (r_out.error_code != ihx_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // Any result other than a data byte sends the parser out of the record phase.
    a_verdict_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid && res.kind != ihx_pkg::KIND_DATA)
            |=> (r_state.phase != ihx_pkg::PH_REC))
        else $error("record verdict left parser inside a record");
`endif

endmodule

// ===== rtl/ihx_step.sv =====
// Single-character decode step of the Intel HEX record parser.
// Pure combinational: current state and one character in, next state and result out.
// Depends on ihx_pkg.
module ihx_step (
    input  ihx_pkg::t_state  i_state,
    input  logic [7:0]       i_ch,
    input  logic             i_final,
    output ihx_pkg::t_state  o_state,
    output logic             o_res_valid,
    output ihx_pkg::t_result o_res
);

    logic [4:0] hex;
    logic [7:0] b;
    logic [8:0] idx;
    logic [8:0] len9;
    logic [8:0] d;

    always_comb begin
        ihx_pkg::t_state n;
        ihx_pkg::t_result res;
        logic res_valid;
        logic do_close;
        logic failed;
        logic [2:0] err;

        n         = i_state;
        res       = '0;
        res_valid = 1'b0;
        do_close  = 1'b0;
        failed    = 1'b0;
        err       = ihx_pkg::ERR_NONE;

        if (i_state.phase == ihx_pkg::PH_WAIT) begin
            if (i_ch != ihx_pkg::CH_COLON) begin
                failed = 1'b1;
                err    = ihx_pkg::ERR_START;
            end else begin
                n.phase          = ihx_pkg::PH_REC;
                n.high_nibble    = '0;
                n.nibble_pending = 1'b0;
                n.byte_index     = '0;
                n.record_length  = '0;
                n.record_offset  = '0;
                n.record_type    = '0;
                n.running_sum    = '0;
                n.pending_base   = '0;
                do_close         = i_final;
            end
        end else if (i_state.phase == ihx_pkg::PH_REC) begin
            if (i_ch == ihx_pkg::CH_LF) begin
                do_close = 1'b1;
            end else if (i_ch == ihx_pkg::CH_CR) begin
                do_close = i_final;
            end else if (!hex[4]) begin
                failed = 1'b1;
                err    = ihx_pkg::ERR_HEX;
            end else if (!i_state.nibble_pending) begin
                n.high_nibble    = hex[3:0];
                n.nibble_pending = 1'b1;
                do_close         = i_final;
            end else begin
                n.nibble_pending = 1'b0;
                if (idx != 9'd0 && idx > ihx_pkg::HDR_BYTES + len9) begin
                    failed = 1'b1;
                    err    = ihx_pkg::ERR_LENGTH;
                end else begin
                    n.running_sum = i_state.running_sum + b;
                    n.byte_index  = idx + 9'd1;
                    priority if (idx == 9'd0) begin
                        n.record_length = b;
                    end else if (idx == 9'd1) begin
                        n.record_offset = {b, 8'h00};
                    end else if (idx == 9'd2) begin
                        n.record_offset = {i_state.record_offset[15:8], b};
                    end else if (idx == 9'd3) begin
                        n.record_type = b;
                        if (b == ihx_pkg::REC_SSA || b == ihx_pkg::REC_SLA) begin
                            failed = 1'b1;
                            err    = ihx_pkg::ERR_START_REC;
                        end else if (b > ihx_pkg::REC_SLA) begin
                            failed = 1'b1;
                            err    = ihx_pkg::ERR_TYPE;
                        end
                    end else if (idx < ihx_pkg::HDR_BYTES + len9) begin
                        if (i_state.record_type == ihx_pkg::REC_DATA) begin
                            res_valid        = 1'b1;
                            res.kind         = ihx_pkg::KIND_DATA;
                            res.data_byte    = b;
                            res.byte_address = i_state.base_address
                                             + {16'h0000, i_state.record_offset}
                                             + {24'h000000, d[7:0]};
                        end else if (i_state.record_type == ihx_pkg::REC_ESA ||
                                     i_state.record_type == ihx_pkg::REC_ELA) begin
                            if (d == 9'd0) begin
                                n.pending_base = {b, 8'h00};
                            end else if (d == 9'd1) begin
                                n.pending_base = {i_state.pending_base[15:8], b};
                            end
                        end
                    end else begin
                        // checksum byte: only the running sum and the byte index move
                    end
                    if (!failed) begin
                        do_close = i_final;
                    end
                end
            end
        end

        // Close the record on the state left by this character.
        if (!failed && do_close) begin
            res_valid = 1'b1;
            res       = '0;
            priority if (n.nibble_pending) begin
                failed = 1'b1;
                err    = ihx_pkg::ERR_HEX;
            end else if (n.byte_index < ihx_pkg::FRAME_BYTES ||
                         n.byte_index != ihx_pkg::FRAME_BYTES + {1'b0, n.record_length}) begin
                failed = 1'b1;
                err    = ihx_pkg::ERR_LENGTH;
            end else if (n.running_sum != 8'h00) begin
                failed = 1'b1;
                err    = ihx_pkg::ERR_CHECKSUM;
            end else if (n.record_type == ihx_pkg::REC_EOF) begin
                if (n.record_length != 8'd0) begin
                    failed = 1'b1;
                    err    = ihx_pkg::ERR_LENGTH;
                end else begin
                    n.phase  = ihx_pkg::PH_HALT;
                    res.kind = ihx_pkg::KIND_EOF;
                end
            end else if (n.record_type == ihx_pkg::REC_ESA ||
                         n.record_type == ihx_pkg::REC_ELA) begin
                if (n.record_length != 8'd2) begin
                    failed = 1'b1;
                    err    = ihx_pkg::ERR_LENGTH;
                end else begin
                    n.phase  = ihx_pkg::PH_WAIT;
                    res.kind = ihx_pkg::KIND_ACCEPT;
                    if (n.record_type == ihx_pkg::REC_ESA) begin
                        n.segment_base = n.pending_base;
                        n.base_address = {12'h000, n.pending_base, 4'h0}
                                       + {n.linear_base, 16'h0000};
                    end else begin
                        n.linear_base  = n.pending_base;
                        n.base_address = {12'h000, n.segment_base, 4'h0}
                                       + {n.pending_base, 16'h0000};
                    end
                end
            end else begin
                n.phase  = ihx_pkg::PH_WAIT;
                res.kind = ihx_pkg::KIND_ACCEPT;
            end
        end

        if (failed) begin
            n.phase        = ihx_pkg::PH_HALT;
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = ihx_pkg::KIND_ERROR;
            res.error_code = err;
        end

        o_state     = n;
        o_res       = res;
        o_res_valid = res_valid;
    end

    assign hex  = ihx_pkg::hex_value(i_ch);
    assign b    = {i_state.high_nibble, hex[3:0]};
    assign idx  = i_state.byte_index;
    assign len9 = {1'b0, i_state.record_length};
    assign d    = idx - ihx_pkg::HDR_BYTES;

endmodule
